@@ design/rcb_pkg.sv @@
// Shared types for the rectangle clip and border split core.
package rcb_pkg;

  // Width of the clipped coordinates and canvas registers
  localparam int unsigned CoordW = 13;
  // Working width of signed coordinates inside the core (covers x + w - b + b)
  localparam int unsigned WideW = 20;

  // Configuration register indexes
  localparam logic CfgCanvasWidth  = 1'b0;
  localparam logic CfgCanvasHeight = 1'b1;

  // Command operations
  localparam logic FuncFill   = 1'b0;
  localparam logic FuncStroke = 1'b1;

  // Input command
  typedef struct packed {
    logic               func;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic signed [15:0] border_px;
    logic [31:0]        color;
  } rcb_in_t;

  // Clipped result rectangle
  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [31:0]       fill_color;
    logic              nonempty;
    logic              last;
  } rcb_out_t;

  // Unclipped sub-rectangle from the splitter
  typedef struct packed {
    logic signed [WideW-1:0] x0;
    logic signed [WideW-1:0] y0;
    logic signed [WideW-1:0] w;
    logic signed [WideW-1:0] h;
    logic [31:0]             color;
    logic                    last;
  } rcb_rect_t;

  // Sign-extend a 16-bit field to the working width
  function automatic logic signed [WideW-1:0] sext16(input logic [15:0] v);
    sext16 = {{(WideW-16){v[15]}}, v};
  endfunction

endpackage

@@ design/rcb_split.sv @@
// Command decode and stroke split into up to four sub-rectangles, one per cycle while rect_ready is high.
module rcb_split import rcb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  rcb_in_t   in_data,
  output logic      rect_valid,
  input  logic      rect_ready,
  output rcb_rect_t rect_data
);

  // Held command
  logic                    held;
  logic                    four;
  logic [1:0]              idx;
  logic signed [WideW-1:0] x, y, w, h, b;
  logic signed [WideW-1:0] y_bot, x_rgt, y_in, h_in;
  logic [31:0]             color;

  // Decode of the incoming command
  logic signed [WideW-1:0] ix, iy, iw, ih, ib, ib2;
  logic                    drop, thick, four_in, accept, last_now;

  always_comb begin
    ix = sext16(in_data.rect_x);
    iy = sext16(in_data.rect_y);
    iw = sext16(in_data.rect_w);
    ih = sext16(in_data.rect_h);
    ib = sext16(in_data.border_px);
    ib2 = ib + ib;
    drop = (in_data.func == FuncStroke) && (ib <= 0);
    thick = (ib2 >= iw) || (ib2 >= ih);
    four_in = (in_data.func == FuncStroke) && !drop && !thick;
  end

  assign last_now = !four || (idx == 2'd3);
  assign in_stall = held && !(rect_ready && last_now);
  assign accept = in_valid && !in_stall;
  assign rect_valid = held;

  // Control: hold a command until its last sub-rectangle transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 2'd0;
    end else if (accept) begin
      held <= !drop;
      idx  <= 2'd0;
    end else if (held && rect_ready) begin
      if (last_now) begin
        held <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Payload: edge offsets are precomputed at load time
  always_ff @(posedge clk) begin
    if (accept) begin
      four  <= four_in;
      x     <= ix;
      y     <= iy;
      w     <= iw;
      h     <= ih;
      b     <= ib;
      y_bot <= iy + ih - ib;
      x_rgt <= ix + iw - ib;
      y_in  <= iy + ib;
      h_in  <= ih - ib2;
      color <= in_data.color;
    end
  end

  // Sub-rectangle select: top, bottom, left, right edges
  always_comb begin
    rect_data.color = color;
    rect_data.last  = last_now;
    rect_data.x0    = x;
    rect_data.y0    = y;
    rect_data.w     = w;
    rect_data.h     = h;
    if (four) begin
      unique case (idx)
        2'd0: begin
          rect_data.h = b;
        end
        2'd1: begin
          rect_data.y0 = y_bot;
          rect_data.h  = b;
        end
        2'd2: begin
          rect_data.y0 = y_in;
          rect_data.w  = b;
          rect_data.h  = h_in;
        end
        default: begin
          rect_data.x0 = x_rgt;
          rect_data.y0 = y_in;
          rect_data.w  = b;
          rect_data.h  = h_in;
        end
      endcase
    end
  end

endmodule

@@ design/rcb_clip.sv @@
// Three-stage clip pipeline: corner order, clamp to canvas, empty test.
module rcb_clip import rcb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CoordW-1:0] canvas_w,
  input  logic [CoordW-1:0] canvas_h,
  input  logic              rect_valid,
  output logic              rect_ready,
  input  rcb_rect_t         rect_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rcb_out_t          out_data
);

  logic s1_v, s2_v, s3_v;
  logic s1_rdy, s2_rdy, s3_rdy;

  // Stage moves when empty or when the next stage moves
  assign s3_rdy = !s3_v || !out_stall;
  assign s2_rdy = !s2_v || s3_rdy;
  assign s1_rdy = !s1_v || s2_rdy;
  assign rect_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (s1_rdy) s1_v <= rect_valid;
      if (s2_rdy) s2_v <= s1_v;
      if (s3_rdy) s3_v <= s2_v;
    end
  end

  // Stage 1: far corner and ordering
  logic signed [WideW-1:0] x1, y1;
  logic signed [WideW-1:0] s1_xl, s1_xh, s1_yl, s1_yh;
  logic [31:0]             s1_color;
  logic                    s1_last;

  assign x1 = rect_data.x0 + rect_data.w;
  assign y1 = rect_data.y0 + rect_data.h;

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_xl    <= (x1 < rect_data.x0) ? x1 : rect_data.x0;
      s1_xh    <= (x1 < rect_data.x0) ? rect_data.x0 : x1;
      s1_yl    <= (y1 < rect_data.y0) ? y1 : rect_data.y0;
      s1_yh    <= (y1 < rect_data.y0) ? rect_data.y0 : y1;
      s1_color <= rect_data.color;
      s1_last  <= rect_data.last;
    end
  end

  // Stage 2: clamp each coordinate to [0, canvas]
  function automatic logic [CoordW-1:0] clamp(input logic signed [WideW-1:0] v,
                                                input logic [CoordW-1:0] hi);
    logic signed [WideW-1:0] hi_w;
    hi_w = {{(WideW-CoordW){1'b0}}, hi};
    if (v < 0) begin
      clamp = '0;
    end else if (v > hi_w) begin
      clamp = hi;
    end else begin
      clamp = v[CoordW-1:0];
    end
  endfunction

  logic [CoordW-1:0] s2_xl, s2_xh, s2_yl, s2_yh;
  logic [31:0]       s2_color;
  logic              s2_last;

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_xl    <= clamp(s1_xl, canvas_w);
      s2_xh    <= clamp(s1_xh, canvas_w);
      s2_yl    <= clamp(s1_yl, canvas_h);
      s2_yh    <= clamp(s1_yh, canvas_h);
      s2_color <= s1_color;
      s2_last  <= s1_last;
    end
  end

  // Stage 3: empty test; empty results carry zero coordinates and color
  logic nonempty;
  assign nonempty = (s2_xh > s2_xl) && (s2_yh > s2_yl);

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      out_data.left       <= nonempty ? s2_xl : '0;
      out_data.top        <= nonempty ? s2_yl : '0;
      out_data.right      <= nonempty ? s2_xh : '0;
      out_data.bottom     <= nonempty ? s2_yh : '0;
      out_data.fill_color <= nonempty ? s2_color : '0;
      out_data.nonempty   <= nonempty;
      out_data.last       <= s2_last;
    end
  end

  assign out_valid = s3_v;

endmodule

@@ design/rect_clip_and_border_split_core.sv @@
// Top level: canvas registers, command splitter and clip pipeline.
//
//  Channel | Handshake                     | Payload
//  --------+-------------------------------+-------------------------------
//  in      | in_valid / in_stall           | in_data (rcb_in_t)
//  out     | out_valid / out_stall         | out_data (rcb_out_t)
//  cfg     | cfg_valid / cfg_ready (=1)    | cfg_index, cfg_data
//
// A fill, or a stroke that degenerates to a full fill, yields one sub-rectangle in
// the splitter; a stroke with a proper border yields four (one per edge), and an
// invalid stroke yields none and no result. The path from input transfer to the
// first result runs through the splitter register and the three clip stages.
// Reset is synchronous; it empties all stages and sets both canvas sizes to
// 4096 (saturated to MAX_DIM). An output stall holds every full stage, empty
// stages keep filling, and the input stalls once the splitter cannot hand off.
module rect_clip_and_border_split_core import rcb_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rcb_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rcb_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CoordW-1:0] cfg_data
);

  // Largest canvas size the 13-bit registers can hold under MAX_DIM
  localparam int unsigned RegMax = (1 << CoordW) - 1;
  localparam int unsigned DimCap = (MAX_DIM > RegMax) ? RegMax : MAX_DIM;
  localparam int unsigned DimRst = (4096 > DimCap) ? DimCap : 4096;

  logic [CoordW-1:0] canvas_w, canvas_h, cfg_sat;

  // Canvas registers hold the already saturated size
  assign cfg_ready = 1'b1;
  assign cfg_sat = (cfg_data > CoordW'(DimCap)) ? CoordW'(DimCap) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_w <= CoordW'(DimRst);
      canvas_h <= CoordW'(DimRst);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgCanvasWidth:  canvas_w <= cfg_sat;
        CfgCanvasHeight: canvas_h <= cfg_sat;
        default:         canvas_w <= canvas_w;
      endcase
    end
  end

  logic      rect_valid, rect_ready;
  rcb_rect_t rect_data;

  rcb_split u_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .rect_valid (rect_valid),
    .rect_ready (rect_ready),
    .rect_data  (rect_data)
  );

  rcb_clip u_clip (
    .clk        (clk),
    .rst        (rst),
    .canvas_w   (canvas_w),
    .canvas_h   (canvas_h),
    .rect_valid (rect_valid),
    .rect_ready (rect_ready),
    .rect_data  (rect_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
